// File: rtl/nrle_pkg.sv
// shared types, constants and slot helpers for the nibble run-length decoder
`default_nettype none
package nrle_pkg;

	localparam int ADDR_BITS = 16;
	localparam int NIB_W = 4;
	localparam int WORD_W = 16;
	localparam int SUM_W = ((ADDR_BITS > WORD_W) ? ADDR_BITS : WORD_W) + 1;
	localparam logic [SUM_W-1:0] ADDR_MAX = SUM_W'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [WORD_W-1:0] OFFSET_MAX = '1;
	localparam logic [NIB_W-1:0] HDR_END = 4'd0;
	localparam logic [NIB_W-1:0] HDR_RUN_MAX = 4'd8;
	localparam logic [NIB_W-1:0] LIT_BIAS = 4'd8;

	typedef struct packed {
		logic             is_end;
		logic [NIB_W-1:0] nib;
		logic [NIB_W-1:0] cnt;
	} cmd_t;

	// nibble mask of slots lo .. lo+n-1 (slot order 7:4, 3:0, 15:12, 11:8)
	function automatic logic [WORD_W-1:0] slot_mask(input logic [1:0] lo,
			input logic [NIB_W-1:0] n);
		logic [WORD_W-1:0] m;
		logic [4:0] hi;
		m = '0;
		hi = {3'b000, lo} + {1'b0, n};
		for (int k = 0; k < 4; k++) begin
			if ((5'(k) >= {3'b000, lo}) && (5'(k) < hi)) begin
				unique case (k)
					0: m[7:4] = 4'hf;
					1: m[3:0] = 4'hf;
					2: m[15:12] = 4'hf;
					default: m[11:8] = 4'hf;
				endcase
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// File: rtl/nrle_front.sv
// front end: header parsing, turns nibbles into place and end commands
`default_nettype none
module nrle_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [nrle_pkg::NIB_W-1:0] in_nib,
	input  wire logic                      q_full,
	output logic                           push,
	output nrle_pkg::cmd_t                 push_cmd
);
	import nrle_pkg::*;

	typedef enum logic [1:0] {MODE_HEADER, MODE_RUN, MODE_LIT} mode_t;

	mode_t            mode_q;
	logic [NIB_W-1:0] rem_q;
	logic             acc;

	assign in_ready = !q_full;
	assign acc = in_valid && !q_full;

	always_comb begin
		push_cmd.is_end = 1'b0;
		push_cmd.nib = in_nib;
		push_cmd.cnt = rem_q;
		push = 1'b0;
		unique case (mode_q)
			MODE_RUN: begin
				push = acc;
			end
			MODE_LIT: begin
				push_cmd.cnt = 4'd1;
				push = acc;
			end
			default: begin
				push_cmd.is_end = 1'b1;
				push_cmd.cnt = '0;
				push = acc && (in_nib == HDR_END);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HEADER;
			rem_q <= '0;
		end else if (acc) begin
			unique case (mode_q)
				MODE_RUN: begin
					mode_q <= MODE_HEADER;
					rem_q <= '0;
				end
				MODE_LIT: begin
					rem_q <= rem_q - 4'd1;
					if (rem_q == 4'd1) begin
						mode_q <= MODE_HEADER;
					end
				end
				default: begin
					priority if (in_nib == HDR_END) begin
						rem_q <= '0;
					end else if (in_nib <= HDR_RUN_MAX) begin
						mode_q <= MODE_RUN;
						rem_q <= in_nib;
					end else begin
						mode_q <= MODE_LIT;
						rem_q <= in_nib - LIT_BIAS;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/nrle_queue.sv
// two-entry command queue between front and back end
`default_nettype none
module nrle_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire nrle_pkg::cmd_t push_cmd,
	output logic                full,
	output logic                head_valid,
	output nrle_pkg::cmd_t      head,
	input  wire logic           pop
);
	import nrle_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/nrle_back.sv
// back end: word packing, address generation and result register
`default_nettype none
module nrle_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [nrle_pkg::WORD_W-1:0] base_word,
	input  wire logic                        head_valid,
	input  wire nrle_pkg::cmd_t              head,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [nrle_pkg::WORD_W-1:0]      word_data,
	output logic [nrle_pkg::WORD_W-1:0]      word_address,
	output logic                             word_valid,
	output logic                             stream_end,
	output logic                             address_overflow,
	output logic                             last
);
	import nrle_pkg::*;

	logic [1:0]        slot_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] off_q;
	logic              ovf_q;
	logic              cont_q;
	logic [NIB_W-1:0]  cont_cnt_q;

	logic              vld_q;
	logic [WORD_W-1:0] data_q;
	logic [WORD_W-1:0] addr_q;
	logic              wv_q;
	logic              end_q;
	logic              aovf_q;
	logic              last_q;

	logic              fire;
	logic [NIB_W-1:0]  cnt;
	logic [2:0]        space;
	logic              fills;
	logic [NIB_W-1:0]  rem;
	logic [WORD_W-1:0] rep;
	logic [WORD_W-1:0] word_full;
	logic [SUM_W-1:0]  sum;
	logic              sat;
	logic [WORD_W-1:0] addr_sel;
	logic              ovf_next;
	logic [WORD_W-1:0] off_next;

	assign fire = head_valid && (!vld_q || out_ready);
	assign cnt = cont_q ? cont_cnt_q : head.cnt;
	assign space = 3'd4 - {1'b0, slot_q};
	assign fills = cnt >= {1'b0, space};
	assign rem = cnt - {1'b0, space};
	assign rep = {4{head.nib}};
	assign word_full = acc_q | (slot_mask(slot_q, {1'b0, space}) & rep);

	assign sum = SUM_W'(base_word) + SUM_W'(off_q);
	assign sat = ovf_q || (sum > ADDR_MAX);
	assign addr_sel = sat ? ADDR_MAX[WORD_W-1:0] : sum[WORD_W-1:0];
	assign ovf_next = sat || (off_q == OFFSET_MAX);
	assign off_next = (off_q == OFFSET_MAX) ? OFFSET_MAX : off_q + 16'd1;

	assign pop = fire && (head.is_end || !fills || (rem < 4'd4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			acc_q <= '0;
			off_q <= '0;
			ovf_q <= 1'b0;
			cont_q <= 1'b0;
			cont_cnt_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (fire && (head.is_end || fills)) begin
				vld_q <= 1'b1;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
			if (fire) begin
				if (head.is_end) begin
					slot_q <= '0;
					acc_q <= '0;
					off_q <= '0;
					ovf_q <= 1'b0;
					cont_q <= 1'b0;
				end else if (fills) begin
					off_q <= off_next;
					ovf_q <= ovf_next;
					if (rem >= 4'd4) begin
						cont_q <= 1'b1;
						cont_cnt_q <= rem;
						slot_q <= '0;
						acc_q <= '0;
					end else begin
						cont_q <= 1'b0;
						slot_q <= rem[1:0];
						acc_q <= slot_mask(2'd0, rem) & rep;
					end
				end else begin
					cont_q <= 1'b0;
					slot_q <= slot_q + cnt[1:0];
					acc_q <= acc_q | (slot_mask(slot_q, cnt) & rep);
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire && (head.is_end || fills)) begin
			if (head.is_end) begin
				wv_q <= (slot_q != 2'd0);
				end_q <= 1'b1;
				last_q <= 1'b1;
				data_q <= (slot_q != 2'd0) ? acc_q : '0;
				addr_q <= (slot_q != 2'd0) ? addr_sel : '0;
				aovf_q <= (slot_q != 2'd0) ? ovf_next : ovf_q;
			end else begin
				wv_q <= 1'b1;
				end_q <= 1'b0;
				last_q <= (rem < 4'd4);
				data_q <= word_full;
				addr_q <= addr_sel;
				aovf_q <= ovf_next;
			end
		end
	end

	assign out_valid = vld_q;
	assign word_data = data_q;
	assign word_address = addr_q;
	assign word_valid = wv_q;
	assign stream_end = end_q;
	assign address_overflow = aovf_q;
	assign last = last_q;

endmodule
`default_nettype wire

// File: rtl/nibble_rle_decoder_word_packer.sv
// top level: nibble run-length decoder with 16-bit word packer
//
// channel | direction | handshake                  | payload
// s_axis  | in        | s_axis_tvalid/tready       | tdata[3:0] compressed_nibble
// m_axis  | out       | m_axis_tvalid/tready       | tdata word_data, word_address;
//         |           |                            | tuser flags; tlast last
// cfg     | in        | cfg_valid/cfg_ready        | cfg_data base_word
//
// one nibble enters per cycle while the command queue is not full; a run that
// completes two words stays at the queue head for the second (one result register slot).
// a two-entry command queue lets the parser run while the result waits.
// reset clears parser mode, queue, packer state and address offset.
// base_word writes take effect at once and are expected only when idle.
`default_nettype none
module nibble_rle_decoder_word_packer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [3:0] compressed_nibble, [7:4] zero
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [15:0] word_data, [31:16] word_address
	output logic [2:0]       m_axis_tuser,  // [0] word_valid, [1] stream_end,
	                                        // [2] address_overflow
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);
	import nrle_pkg::*;

	logic [WORD_W-1:0] base_q;
	logic              q_full;
	logic              push;
	cmd_t              push_cmd;
	logic              head_valid;
	cmd_t              head;
	logic              pop;
	logic [WORD_W-1:0] word_data;
	logic [WORD_W-1:0] word_address;
	logic              word_valid;
	logic              stream_end;
	logic              address_overflow;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	nrle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_nib   (s_axis_tdata[3:0]),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	nrle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	nrle_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.base_word        (base_q),
		.head_valid       (head_valid),
		.head             (head),
		.pop              (pop),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.word_data        (word_data),
		.word_address     (word_address),
		.word_valid       (word_valid),
		.stream_end       (stream_end),
		.address_overflow (address_overflow),
		.last             (m_axis_tlast)
	);

	assign m_axis_tdata = {word_address, word_data};
	assign m_axis_tuser = {address_overflow, stream_end, word_valid};

`ifndef SYNTHESIS
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && stream_end |-> m_axis_tlast)
		else $error("end result not marked last");
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !word_valid |-> stream_end && (word_data == '0)
			&& (word_address == '0))
		else $error("empty result outside stream end");
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command pop from empty queue");
`endif

endmodule
`default_nettype wire

// File: dv/tb_nibble_rle_decoder_word_packer.sv
// testbench: random and directed nibble streams checked against a word-level predictor
`timescale 1ns / 1ps
module tb_nibble_rle_decoder_word_packer;
	import nrle_pkg::*;

	typedef enum logic [1:0] {
		EXPECT_HEADER,
		RUN_VALUE,
		LITERAL_DATA
	} decode_mode_t;

	typedef struct {
		logic [15:0] word_data;
		logic [15:0] word_address;
		logic        word_valid;
		logic        stream_end;
		logic        address_overflow;
		logic        last;
	} packed_word_t;

	class word_scoreboard;
		packed_word_t expected_words[$];
		logic [15:0]  base_word;
		decode_mode_t mode;
		logic [3:0]   remaining;
		logic [1:0]   slot;
		logic [15:0]  acc;
		logic [15:0]  offset;
		logic         saturated;
		int           errors;
		int           words_checked;
		int           ends_seen;
		int           saturated_seen;

		function new();
			base_word = '0;
			errors = 0;
			words_checked = 0;
			ends_seen = 0;
			saturated_seen = 0;
			restart();
		endfunction

		function void restart();
			mode = EXPECT_HEADER;
			remaining = '0;
			slot = '0;
			acc = '0;
			offset = '0;
			saturated = 1'b0;
		endfunction

		function void set_base(input logic [15:0] value);
			base_word = value;
		endfunction

		function logic [15:0] take_address();
			logic [16:0] sum;
			sum = {1'b0, base_word} + {1'b0, offset};
			if (saturated || sum > {1'b0, 16'hFFFF}) begin
				sum = {1'b0, 16'hFFFF};
				saturated = 1'b1;
			end
			if (offset == OFFSET_MAX)
				saturated = 1'b1;
			else
				offset = offset + 16'd1;
			return sum[15:0];
		endfunction

		function void push_word(input logic [15:0] data, input logic [15:0] addr,
				input logic valid, input logic fin);
			packed_word_t w;
			w.word_data = data;
			w.word_address = addr;
			w.word_valid = valid;
			w.stream_end = fin;
			w.address_overflow = saturated;
			w.last = 1'b0;
			expected_words.push_back(w);
		endfunction

		function void place(input logic [3:0] nib);
			logic [15:0] addr;
			case (slot)
				2'd0: acc = {8'h00, nib, 4'h0};
				2'd1: acc = acc | {12'h000, nib};
				2'd2: acc = acc | {nib, 12'h000};
				default: acc = acc | {4'h0, nib, 8'h00};
			endcase
			if (slot == 2'd3) begin
				addr = take_address();
				push_word(acc, addr, 1'b1, 1'b0);
				acc = '0;
			end
			slot = slot + 2'd1;
		endfunction

		function void note_nibble(input logic [3:0] nib);
			int queued;
			packed_word_t w;
			logic [15:0] addr;
			queued = expected_words.size();
			case (mode)
				RUN_VALUE: begin
					for (int i = 0; i < remaining; i++)
						place(nib);
					remaining = '0;
					mode = EXPECT_HEADER;
				end
				LITERAL_DATA: begin
					place(nib);
					remaining = remaining - 4'd1;
					if (remaining == 4'd0)
						mode = EXPECT_HEADER;
				end
				default: begin
					if (nib == HDR_END) begin
						if (slot != 2'd0) begin
							addr = take_address();
							push_word(acc, addr, 1'b1, 1'b1);
						end else begin
							push_word(16'h0000, 16'h0000, 1'b0, 1'b1);
						end
						restart();
					end else if (nib <= HDR_RUN_MAX) begin
						remaining = nib;
						mode = RUN_VALUE;
					end else begin
						remaining = nib - LIT_BIAS;
						mode = LITERAL_DATA;
					end
				end
			endcase
			if (expected_words.size() > queued) begin
				w = expected_words.pop_back();
				w.last = 1'b1;
				expected_words.push_back(w);
			end
		endfunction

		function void compare(input string field, input logic [15:0] exp_val,
				input logic [15:0] act_val);
			if (exp_val !== act_val) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_result(input logic [31:0] data, input logic [2:0] flags,
				input logic tail);
			packed_word_t w;
			if (expected_words.size() == 0) begin
				$error("result with nothing expected: tdata 0x%0h tuser 0x%0h", data, flags);
				errors++;
				return;
			end
			w = expected_words.pop_front();
			compare("word_data", w.word_data, data[15:0]);
			compare("word_address", w.word_address, data[31:16]);
			compare("word_valid", 16'(w.word_valid), 16'(flags[0]));
			compare("stream_end", 16'(w.stream_end), 16'(flags[1]));
			compare("address_overflow", 16'(w.address_overflow), 16'(flags[2]));
			compare("last", 16'(w.last), 16'(tail));
			words_checked++;
			if (w.stream_end)
				ends_seen++;
			if (w.address_overflow)
				saturated_seen++;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	word_scoreboard sb = new();
	int sender_idle_pct = 28;
	int receiver_idle_pct = 56;
	int nibbles_sent = 0;

	nibble_rle_decoder_word_packer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// result side: check at the edge, then pick next ready
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	task automatic send_nibble(input logic [3:0] nib);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'h0, nib};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_nibble(nib);
		nibbles_sent++;
	endtask

	task automatic send_run(input logic [3:0] count, input logic [3:0] value);
		send_nibble(count);
		send_nibble(value);
	endtask

	task automatic send_literals(input int n);
		send_nibble(LIT_BIAS + 4'(n));
		repeat (n)
			send_nibble(4'($urandom_range(0, 15)));
	endtask

	task automatic send_random_command();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			send_nibble(HDR_END);
		else if (pick < 16)
			send_nibble(4'($urandom_range(0, 15)));
		else if (pick < 56)
			send_run(4'($urandom_range(1, 8)), 4'($urandom_range(0, 15)));
		else
			send_literals($urandom_range(1, 7));
	endtask

	// wait for every expected word, then let a header still in flight settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_base(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_base(value);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int items);
		int target;
		target = nibbles_sent + items;
		while (nibbles_sent < target)
			send_random_command();
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_base(16'hFFFA);
		send_nibble(HDR_END);
		send_run(4'd1, 4'hF);
		send_literals(1);
		send_literals(7);
		send_run(HDR_RUN_MAX, 4'hA);
		send_run(HDR_RUN_MAX, 4'h0);
		send_run(HDR_RUN_MAX, 4'h5);
		send_run(4'd2, 4'hC);
		send_nibble(HDR_END);
		send_nibble(HDR_END);
		drain();

		write_base(16'h0000);
		random_phase(290);

		sender_idle_pct = 56;
		receiver_idle_pct = 28;
		write_base(16'hFFFF);
		random_phase(320);

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		write_base(16'($urandom_range(0, 65535)));
		random_phase(320);

		repeat (20) @(posedge clk);
		$display("run covered %0d nibbles and %0d checked words", nibbles_sent,
			sb.words_checked);
		$display("%0d stream ends, %0d words with a saturated address", sb.ends_seen,
			sb.saturated_seen);
		if (sb.errors == 0 && sb.expected_words.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: nibble_rle_decoder_word_packer.f
rtl/nrle_pkg.sv
rtl/nrle_front.sv
rtl/nrle_queue.sv
rtl/nrle_back.sv
rtl/nibble_rle_decoder_word_packer.sv
dv/tb_nibble_rle_decoder_word_packer.sv
